/* rtl/core/lrupr_pkg.sv */
// Shared constants, types and helpers for the LRU page replacement block.
package lrupr_pkg;

    localparam int MAX_FRAMES  = 16;
    localparam int PAGE_BITS   = 16;
    localparam int FRAME_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W      = FRAME_IDX_W;
    localparam int TREE_N      = 2 ** FRAME_IDX_W;
    localparam int CFG_W       = 5;
    localparam int CNT_W       = ($clog2(MAX_FRAMES + 1) > CFG_W) ?
                                 $clog2(MAX_FRAMES + 1) : CFG_W;
    localparam int MISS_W      = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    localparam logic [RANK_W-1:0]    RANK_MAX      = RANK_W'(MAX_FRAMES - 1);
    localparam logic [CFG_W-1:0]     FRAMES_RESET  = CFG_W'(16);
    localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = REG_IDX_W'(0);

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_BITS-1:0]   evicted_page;
        logic [MISS_W-1:0]      miss_total;
    } t_result;

    typedef struct packed {
        logic [MAX_FRAMES-1:0] frame_valid;
        logic [MISS_W-1:0]     miss_count;
    } t_status;

    // Index of the single set bit of a one-hot vector (zero when empty).
    function automatic logic [FRAME_IDX_W-1:0] onehot_to_idx(
        input logic [MAX_FRAMES-1:0] oh
    );
        logic [FRAME_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (oh[i]) begin
                idx = idx | FRAME_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/core/lrupr_if.sv */
// Request and result channel interfaces.
interface lrupr_req_if;
    logic                           valid;
    logic                           ready;
    logic [lrupr_pkg::PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index;
    logic                             evicted_valid;
    logic [lrupr_pkg::PAGE_BITS-1:0]   evicted_page;
    logic [lrupr_pkg::MISS_W-1:0]      miss_total;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output miss_total, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input miss_total, output ready);
endinterface

/* rtl/core/lrupr_cfg_regs.sv */
// APB configuration register: frames_in_use.
module lrupr_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lrupr_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output logic [lrupr_pkg::CFG_W-1:0]      o_frames_in_use
);

    logic [lrupr_pkg::CFG_W-1:0]     r_frames_in_use;
    logic [lrupr_pkg::REG_IDX_W-1:0] reg_idx;
    logic                            wr_en;

    assign reg_idx = paddr[lrupr_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite &&
                     (reg_idx == lrupr_pkg::REG_FRAMES_IN_USE);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= lrupr_pkg::FRAMES_RESET;
        end else if (wr_en) begin
            r_frames_in_use <= pwdata[lrupr_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == lrupr_pkg::REG_FRAMES_IN_USE) begin
            prdata = lrupr_pkg::APB_DATA_W'(r_frames_in_use);
        end
    end

    assign o_frames_in_use = r_frames_in_use;

endmodule

/* rtl/core/lrupr_policy.sv */
// Frame table, tag search, victim selection and recency update.
module lrupr_policy (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lrupr_pkg::CFG_W-1:0]     i_frames_in_use,
    input  logic [lrupr_pkg::PAGE_BITS-1:0] i_page,
    input  logic                            i_commit,
    output lrupr_pkg::t_result              o_result,
    output lrupr_pkg::t_status              o_status
);

    localparam int NF  = lrupr_pkg::MAX_FRAMES;
    localparam int IW  = lrupr_pkg::FRAME_IDX_W;
    localparam int RW  = lrupr_pkg::RANK_W;
    localparam int TN  = lrupr_pkg::TREE_N;

    logic [lrupr_pkg::PAGE_BITS-1:0] r_page  [NF];
    logic [RW-1:0]                   r_rank  [NF];
    logic [NF-1:0]                   r_valid;
    logic [lrupr_pkg::MISS_W-1:0]    r_miss;
    logic [lrupr_pkg::MISS_W-1:0]    n_miss;

    logic [lrupr_pkg::CNT_W-1:0] active_cnt;
    logic [NF-1:0]               active;
    logic [NF-1:0]               hit_vec;
    logic [NF-1:0]               empty_vec;
    logic [NF-1:0]               hit_oh;
    logic [NF-1:0]               empty_oh;
    logic                        found;
    logic                        any_empty;
    logic [IW-1:0]               victim_idx;
    logic [IW-1:0]               f_idx;
    logic [RW-1:0]               f_rank;
    logic [RW:0]                 age_limit;
    logic                        evict;

    // Heap-ordered max tree over ranks; lower index wins ties.
    logic          t_pres [1:2*TN-1];
    logic [RW-1:0] t_rank [1:2*TN-1];
    logic [IW-1:0] t_idx  [1:2*TN-1];

    always_comb begin
        if (i_frames_in_use == '0) begin
            active_cnt = lrupr_pkg::CNT_W'(1);
        end else if (lrupr_pkg::CNT_W'(i_frames_in_use) > lrupr_pkg::CNT_W'(NF)) begin
            active_cnt = lrupr_pkg::CNT_W'(NF);
        end else begin
            active_cnt = lrupr_pkg::CNT_W'(i_frames_in_use);
        end
    end

    for (genvar i = 0; i < NF; i++) begin : g_match
        assign active[i]    = lrupr_pkg::CNT_W'(i) < active_cnt;
        assign hit_vec[i]   = active[i] && r_valid[i] && (r_page[i] == i_page);
        assign empty_vec[i] = active[i] && !r_valid[i];
    end

    assign hit_oh    = hit_vec & (~hit_vec + NF'(1));
    assign empty_oh  = empty_vec & (~empty_vec + NF'(1));
    assign found     = |hit_vec;
    assign any_empty = |empty_vec;

    for (genvar i = 0; i < TN; i++) begin : g_leaf
        if (i < NF) begin : g_real
            assign t_pres[TN+i] = active[i];
            assign t_rank[TN+i] = r_rank[i];
        end else begin : g_pad
            assign t_pres[TN+i] = 1'b0;
            assign t_rank[TN+i] = '0;
        end
        assign t_idx[TN+i] = IW'(i);
    end

    for (genvar k = 1; k < TN; k++) begin : g_node
        logic take_right;
        assign take_right = t_pres[2*k+1] &&
                            (!t_pres[2*k] || (t_rank[2*k+1] > t_rank[2*k]));
        assign t_pres[k] = t_pres[2*k] || t_pres[2*k+1];
        assign t_rank[k] = take_right ? t_rank[2*k+1] : t_rank[2*k];
        assign t_idx[k]  = take_right ? t_idx[2*k+1]  : t_idx[2*k];
    end

    assign victim_idx = t_idx[1];

    always_comb begin
        priority if (found) begin
            f_idx = lrupr_pkg::onehot_to_idx(hit_oh);
        end else if (any_empty) begin
            f_idx = lrupr_pkg::onehot_to_idx(empty_oh);
        end else begin
            f_idx = victim_idx;
        end
    end

    assign f_rank = r_rank[f_idx];
    assign evict  = !found && !any_empty;
    // Filling an empty frame ages every valid frame in use.
    assign age_limit = (!found && any_empty) ? (RW+1)'(NF) : {1'b0, f_rank};
    assign n_miss    = (r_miss != '1) ? r_miss + 1'b1 : r_miss;

    for (genvar i = 0; i < NF; i++) begin : g_frame
        logic sel;
        assign sel = (f_idx == IW'(i));

        always_ff @(posedge i_clk) begin
            if (i_commit && !found && sel) begin
                r_page[i] <= i_page;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end else if (i_commit && active[i]) begin
                if (sel) begin
                    r_valid[i] <= 1'b1;
                    r_rank[i]  <= '0;
                end else if (r_valid[i] && ({1'b0, r_rank[i]} < age_limit) &&
                             (r_rank[i] != lrupr_pkg::RANK_MAX)) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss <= '0;
        end else if (i_commit && !found) begin
            r_miss <= n_miss;
        end
    end

    always_comb begin
        o_result.hit           = found;
        o_result.frame_index   = f_idx;
        o_result.evicted_valid = evict;
        o_result.evicted_page  = evict ? r_page[f_idx] : '0;
        o_result.miss_total    = found ? r_miss : n_miss;
    end

    assign o_status.frame_valid = r_valid;
    assign o_status.miss_count  = r_miss;

endmodule

/* rtl/core/lru_page_replacement.sv */
// Fully associative LRU page replacement block: one page reference per clock
// while results are taken; a request passes the input register, then the
// result register. Throughput is one reference per cycle when not stalled;
// the limit is the loop from the frame table through the tag compares, the rank
// max tree and the rank update back into the table. A stalled result holds
// the pipe; one further request waits in the input register meanwhile.
module lru_page_replacement (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lrupr_req_if.sink                        i_req,
    lrupr_rsp_if.source                      o_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lrupr_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);

    logic [lrupr_pkg::CFG_W-1:0]     frames_in_use;
    logic                            r_in_valid;
    logic [lrupr_pkg::PAGE_BITS-1:0] r_in_page;
    logic                            r_out_valid;
    lrupr_pkg::t_result              r_out;
    lrupr_pkg::t_result              w_result;
    lrupr_pkg::t_status              w_status;
    logic                            advance;
    logic                            in_ready;

    lrupr_cfg_regs u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_frames_in_use (frames_in_use)
    );

    lrupr_policy u_policy (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frames_in_use (frames_in_use),
        .i_page          (r_in_page),
        .i_commit        (advance),
        .o_result        (w_result),
        .o_status        (w_status)
    );

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready    = !r_in_valid || advance;
    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_in_page <= i_req.page_number;
        end
        if (advance) begin
            r_out <= w_result;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out.hit;
    assign o_rsp.frame_index   = r_out.frame_index;
    assign o_rsp.evicted_valid = r_out.evicted_valid;
    assign o_rsp.evicted_page  = r_out.evicted_page;
    assign o_rsp.miss_total    = r_out.miss_total;

    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && w_result.hit |-> !w_result.evicted_valid)
        else $error("eviction reported on a hit");

    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        ((w_status.frame_valid & $past(w_status.frame_valid)) ==
         $past(w_status.frame_valid)))
        else $error("frame valid bit cleared outside reset");

    a_miss_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (w_status.miss_count >= $past(w_status.miss_count)))
        else $error("miss counter decreased");

    a_miss_on_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !w_result.hit |=> (w_status.miss_count != '0))
        else $error("miss counter zero after a miss");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the LRU page replacement block.
import lrupr_pkg::*;

// Tracks the frame table, orders the expected results, and checks each result.
class lru_tracker;
    logic [PAGE_BITS-1:0] page_of [MAX_FRAMES];
    bit                   valid_of [MAX_FRAMES];
    int                   age_of [MAX_FRAMES];
    logic [MISS_W-1:0]    misses;
    logic [CFG_W-1:0]     frames_reg;
    t_result              due_results [$];
    int accepted;
    int checked;
    int errors;
    int hits;
    int replacements;

    function void clear_state();
        for (int i = 0; i < MAX_FRAMES; i++) begin
            page_of[i]  = '0;
            valid_of[i] = 1'b0;
            age_of[i]   = 0;
        end
        misses     = '0;
        frames_reg = FRAMES_RESET;
    endfunction

    function void write_reg(input int idx, input logic [APB_DATA_W-1:0] data);
        if (idx == int'(REG_FRAMES_IN_USE)) begin
            frames_reg = data[CFG_W-1:0];
        end
    endfunction

    function int active_frames();
        if (frames_reg == 0) return 1;
        if (frames_reg > MAX_FRAMES) return MAX_FRAMES;
        return int'(frames_reg);
    endfunction

    // Younger frames in use age by one (saturating); frame f becomes newest.
    function void age_others(input int f, input int limit, input int n);
        for (int i = 0; i < n; i++) begin
            if (i != f && valid_of[i] && age_of[i] < limit && age_of[i] < MAX_FRAMES - 1) begin
                age_of[i]++;
            end
        end
        age_of[f] = 0;
    endfunction

    function void note_reference(input logic [PAGE_BITS-1:0] page);
        t_result r;
        int      n;
        int      f;
        int      top;
        bit      found;
        bit      has_empty;
        r         = '0;
        n         = active_frames();
        f         = 0;
        found     = 1'b0;
        has_empty = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!found && valid_of[i] && page_of[i] == page) begin
                f     = i;
                found = 1'b1;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            hits++;
            age_others(f, age_of[f], n);
        end else begin
            for (int i = 0; i < n; i++) begin
                if (!has_empty && !valid_of[i]) begin
                    f         = i;
                    has_empty = 1'b1;
                end
            end
            if (has_empty) begin
                age_others(f, MAX_FRAMES, n);
            end else begin
                // oldest frame wins; ties go to the lowest index
                top = 0;
                f   = 0;
                for (int i = 0; i < n; i++) begin
                    if (age_of[i] > top) begin
                        top = age_of[i];
                        f   = i;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = page_of[f];
                replacements++;
                age_others(f, age_of[f], n);
            end
            page_of[f]  = page;
            valid_of[f] = 1'b1;
            if (misses != '1) misses++;
        end
        r.frame_index = FRAME_IDX_W'(f);
        r.miss_total  = misses;
        due_results.insert(due_results.size(), r);
        accepted++;
    endfunction

    function void check_outcome(input t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected result: hit=%0d frame=%0d evict=%0d/%h misses=%0d",
                         got.hit, got.frame_index, got.evicted_valid, got.evicted_page,
                         got.miss_total);
            end
            return;
        end
        want = due_results[0];
        due_results.delete(0);
        checked++;
        if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
            got.evicted_valid !== want.evicted_valid ||
            got.evicted_page !== want.evicted_page || got.miss_total !== want.miss_total) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch on result %0d: want hit=%0d frame=%0d evict=%0d/%h misses=%0d",
                         checked, want.hit, want.frame_index, want.evicted_valid,
                         want.evicted_page, want.miss_total);
                $display("    got hit=%0d frame=%0d evict=%0d/%h misses=%0d",
                         got.hit, got.frame_index, got.evicted_valid, got.evicted_page,
                         got.miss_total);
            end
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;
    localparam int POOL_MAX    = MAX_FRAMES + 4;
    localparam logic [APB_ADDR_W-1:0] ADDR_FRAMES = APB_ADDR_W'(4 * REG_FRAMES_IN_USE);
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = APB_ADDR_W'(4);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lrupr_req_if req_ch ();
    lrupr_rsp_if rsp_ch ();

    lru_page_replacement dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lru_tracker tracker = new();
    bit         idle_on = 1'b1;
    bit         hold_request = 1'b0;
    int         cycles = 0;
    int         reg_writes = 0;
    t_result    seen;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     tracker.due_results.size());
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
            seen.hit           = rsp_ch.hit;
            seen.frame_index   = rsp_ch.frame_index;
            seen.evicted_valid = rsp_ch.evicted_valid;
            seen.evicted_page  = rsp_ch.evicted_page;
            seen.miss_total    = rsp_ch.miss_total;
            tracker.check_outcome(seen);
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= !i_rst_n ? 1'b0 : (!idle_on || $urandom_range(99) >= 6);
            end
        end
    end

    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 6) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.page_number <= page;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        tracker.note_reference(page);
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic drain_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        tracker.write_reg(int'(addr) >> 2, data);
        reg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [PAGE_BITS-1:0] pool [POOL_MAX];
        logic [CFG_W-1:0]     cfg;
        logic [PAGE_BITS-1:0] page;
        int                   phase;
        int                   npool;
        int                   len;

        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.page_number = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        tracker.clear_state();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset count of frames: fills and a hit, extreme page numbers.
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h5555);
        send_page(16'hAAAA);
        // Count of zero acts as a single frame, which is replaced on a miss.
        write_reg(ADDR_FRAMES, {$urandom} & ~32'h1F);
        send_page(16'h1234);
        send_page(16'h1234);
        send_page(16'hFFFF);
        // Write to another index must be ignored.
        write_reg(ADDR_UNUSED, 32'd16);
        send_page(16'hFFFF);
        // Oversized count saturates; frame 1 kept its page, so FFFF is resident twice.
        write_reg(ADDR_FRAMES, 32'd31);
        send_page(16'hFFFF);
        send_page(16'h00FF);
        send_page(16'hFF00);
        // Small window over stale ranks: evictions and rank ties.
        write_reg(ADDR_FRAMES, 32'd3);
        send_page(16'h0F0F);
        send_page(16'hF0F0);
        send_page(16'h3C3C);
        send_page(16'h0F0F);
        send_page(16'hC3C3);
        write_reg(ADDR_FRAMES, 32'd16);
        send_page(16'h3C3C);
        send_page(16'hC3C3);

        for (int i = 0; i < POOL_MAX; i++) pool[i] = PAGE_BITS'($urandom);
        phase = 0;
        while (tracker.accepted < 720) begin
            if (phase == 0) begin
                cfg = CFG_W'(16);
            end else if (phase == 1) begin
                cfg = CFG_W'(1);
            end else begin
                case ($urandom_range(9))
                    0:       cfg = CFG_W'(1);
                    1:       cfg = CFG_W'(16);
                    2:       cfg = CFG_W'(0);
                    3:       cfg = CFG_W'($urandom_range(31, 17));
                    default: cfg = CFG_W'($urandom_range(16, 1));
                endcase
            end
            if ($urandom_range(3) == 0) write_reg(ADDR_UNUSED, $urandom);
            write_reg(ADDR_FRAMES, ({$urandom} & ~32'h1F) | 32'(cfg));
            idle_on = (phase != 2);
            npool   = tracker.active_frames() + $urandom_range(4);
            // refresh part of the pool; the rest may still sit in frames
            for (int i = 0; i < POOL_MAX; i++) begin
                if ($urandom_range(1) == 0) pool[i] = PAGE_BITS'($urandom);
            end
            len = (phase == 2) ? 120 : $urandom_range(70, 30);
            for (int k = 0; k < len; k++) begin
                if (phase == 3 && k == 5) hold_request = 1'b1;
                if (phase == 4 && k == len / 2) drain_results();
                if ($urandom_range(9) == 0) begin
                    page = PAGE_BITS'($urandom);
                end else begin
                    page = pool[$urandom_range(npool - 1)];
                end
                send_page(page);
            end
            phase++;
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("%0d page references checked: %0d hits, %0d replacements, %0d misses",
                 tracker.checked, tracker.hits, tracker.replacements, tracker.misses);
        $display("%0d register writes across %0d phases of frame counts", reg_writes, phase);
        if (tracker.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d errors", tracker.errors);
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
